[hdl/pfu_pkg.sv]
package pfu_pkg;

    localparam int unsigned MaxParticlesDef = 512;

    localparam logic [31:0] LcgMul = 32'd1103515245;
    localparam logic [31:0] LcgAdd = 32'd12345;
    localparam logic [31:0] RngReset = 32'd12345;
    localparam logic [31:0] MinInterval = 32'd655;
    localparam logic [16:0] OneQ16 = 17'd65536;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_READ = 2'd1,
        OP_FOG  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_KIND  = 2'd0,
        REG_STR   = 2'd1,
        REG_WIND  = 2'd2,
        REG_UNUSED = 2'd3
    } t_reg;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_FOG  = 3'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ,
        S_FOG1,
        S_FOG2,
        S_DIV_INIT,
        S_DIV,
        S_SPAWN_CHK,
        S_DRAW,
        S_SCALE,
        S_SCALE2,
        S_SPAWN_WR,
        S_WIND,
        S_WIND2,
        S_MV_RD,
        S_MV_MUL,
        S_MV_ADD,
        S_MV_CHK,
        S_CP_RD,
        S_CP_WR,
        S_DONE
    } t_state;

endpackage

[hdl/particle_field_update_unit.sv]
// Weather particle field engine.
// Configure through the APB port: weather kind (byte 0), strength (byte 4),
// wind (byte 8). Writing kind or strength empties the table and spawn clock.
// Issue an item by raising i_start with the operation fields while o_busy is
// low; the item is taken at that edge and o_busy rises the next cycle.
// Each item returns exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall the block. o_busy is already low in that cycle,
// so the next item may be taken at the edge that ends it.
// A read passes S_READ, S_CP_RD and S_CP_WR (S_READ only when the index is
// not live), a fog blend S_FOG1 and S_FOG2, an idle or unknown item S_DONE.
// A tick runs a 33-step restoring divider for the spawn interval, then
// draws each spawned particle (four draws through one shared multiplier),
// then reads, moves and checks each entry, copying the last entry over a
// removed one, all through one table port.
// One item is in flight at a time.
// Reset: rng 12345, empty table, timer zero, registers zero. The table
// holds no reset; only entries below the live count are ever read.
module particle_field_update_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    output logic               o_done,
    input  logic [1:0]         i_operation,
    input  logic [23:0]        i_time_step,
    input  logic [8:0]         i_particle_index,
    input  logic [7:0]         i_pixel_in,
    output logic [9:0]         o_live_count,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic [25:0]        o_fall_speed,
    output logic [25:0]        o_streak_length,
    output logic [16:0]        o_particle_alpha,
    output logic               o_entry_valid,
    output logic [7:0]         o_pixel_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pfu_pkg::*;

    localparam int unsigned MAX_PARTICLES = MaxParticlesDef;
    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] MaxCnt = CW'(MAX_PARTICLES);
    localparam int EW = 32 + 32 + 26 + 26 + 17;

    // config registers
    logic [2:0]  r_kind;
    logic [16:0] r_str;
    logic [23:0] r_wind;
    logic        w_cfg_wr;
    t_reg        w_reg;
    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign w_reg = t_reg'(paddr[3:2]);

    always_comb begin
        unique case (w_reg)
            REG_KIND: prdata = {29'd0, r_kind};
            REG_STR:  prdata = {15'd0, r_str};
            REG_WIND: prdata = {8'd0, r_wind};
            default:  prdata = 32'd0;
        endcase
    end

    // table memory: one port, registered read
    logic [EW-1:0] r_mem [MAX_PARTICLES];
    logic [EW-1:0] r_rdata;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_addr;
    logic [EW-1:0] w_mem_wdata;
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_mem_addr];
    end

    // state
    t_state r_st, n_st;
    logic [31:0] r_rng, n_rng;
    logic [31:0] r_clk, n_clk;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic [23:0] r_dt, n_dt;
    logic [8:0]  r_pidx, n_pidx;
    logic [7:0]  r_pix, n_pix;
    // shared datapath registers
    logic [63:0] r_acc, n_acc;     // divider remainder / product
    logic [32:0] r_q, n_q;         // quotient / interval
    logic [5:0]  r_step, n_step;
    logic [1:0]  r_dn, n_dn;       // draw number
    logic [31:0] r_x, n_x;
    logic [31:0] r_y, n_y;
    logic [25:0] r_sp, n_sp;
    logic [25:0] r_ln, n_ln;
    logic [16:0] r_al, n_al;
    logic signed [31:0] r_wd, n_wd;
    logic [31:0] r_wnd_mag;
    // result registers
    logic        r_done, n_done;
    logic [31:0] r_ox, n_ox, r_oy, n_oy;
    logic [25:0] r_osp, n_osp, r_oln, n_oln;
    logic [16:0] r_oal, n_oal;
    logic        r_ov, n_ov;
    logic [7:0]  r_opx, n_opx;

    // shared multiplier 32x32
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic [63:0] w_dsub;
    logic [31:0] w_draw;
    logic signed [35:0] w_ny, w_nx;
    logic signed [31:0] w_sy, w_sx;
    logic [32:0] w_csum;
    logic [23:0] w_wabs;

    assign w_wabs = r_wind[23] ? 24'(-r_wind) : r_wind;
    assign r_wnd_mag = {8'd0, w_wabs};
    assign w_draw = {17'd0, r_rng[30:16]};

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] res;
        if (v > 36'sd2147483647) res = 32'h7FFFFFFF;
        else if (v < -36'sd2147483648) res = 32'h80000000;
        else res = v[31:0];
        return res;
    endfunction

    assign o_busy = (r_st != S_IDLE);
    assign o_done = r_done;
    assign o_live_count = 10'(r_cnt);
    assign o_pos_x = r_ox;
    assign o_pos_y = r_oy;
    assign o_fall_speed = r_osp;
    assign o_streak_length = r_oln;
    assign o_particle_alpha = r_oal;
    assign o_entry_valid = r_ov;
    assign o_pixel_out = r_opx;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_kind <= 3'd0;
            r_str <= 17'd0;
            r_wind <= 24'd0;
            r_rng <= RngReset;
            r_clk <= 32'd0;
            r_cnt <= '0;
            r_done <= 1'b0;
        end else begin
            r_st <= n_st;
            r_rng <= n_rng;
            r_clk <= n_clk;
            r_cnt <= n_cnt;
            r_done <= n_done;
            if (w_cfg_wr) begin
                unique case (w_reg)
                    REG_KIND: begin
                        r_kind <= pwdata[2:0];
                        r_cnt <= '0;
                        r_clk <= 32'd0;
                    end
                    REG_STR: begin
                        r_str <= (pwdata[16:0] > OneQ16) ? OneQ16 : pwdata[16:0];
                        r_cnt <= '0;
                        r_clk <= 32'd0;
                    end
                    REG_WIND: r_wind <= pwdata[23:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_dt <= n_dt; r_pidx <= n_pidx; r_pix <= n_pix;
        r_acc <= n_acc; r_q <= n_q; r_step <= n_step; r_dn <= n_dn;
        r_x <= n_x; r_y <= n_y; r_sp <= n_sp; r_ln <= n_ln; r_al <= n_al; r_wd <= n_wd;
        r_ox <= n_ox; r_oy <= n_oy; r_osp <= n_osp; r_oln <= n_oln; r_oal <= n_oal;
        r_ov <= n_ov; r_opx <= n_opx;
    end

    // sequencer
    always_comb begin
        n_st = r_st; n_rng = r_rng; n_clk = r_clk; n_cnt = r_cnt; n_idx = r_idx;
        n_dt = r_dt; n_pidx = r_pidx; n_pix = r_pix;
        n_acc = r_acc; n_q = r_q; n_step = r_step; n_dn = r_dn;
        n_x = r_x; n_y = r_y; n_sp = r_sp; n_ln = r_ln; n_al = r_al; n_wd = r_wd;
        n_ox = r_ox; n_oy = r_oy; n_osp = r_osp; n_oln = r_oln; n_oal = r_oal;
        n_ov = r_ov; n_opx = r_opx;
        n_done = 1'b0;
        w_mem_we = 1'b0;
        w_mem_addr = r_idx[AW-1:0];
        w_mem_wdata = {r_x, r_y, r_sp, r_ln, r_al};
        w_ma = 32'd0;
        w_mb = 32'd0;
        w_dsub = 64'd0;
        w_ny = '0; w_nx = '0; w_sy = '0; w_sx = '0;
        w_csum = 33'd0;
        unique case (r_st)
            S_IDLE: begin
                if (i_start) begin
                    n_dt = i_time_step;
                    n_pidx = i_particle_index; n_pix = i_pixel_in;
                    n_ox = '0; n_oy = '0; n_osp = '0; n_oln = '0; n_oal = '0;
                    n_ov = 1'b0; n_opx = '0;
                    unique case (t_op'(i_operation))
                        OP_TICK: n_st = (r_kind == KIND_NONE || r_str == 17'd0)
                                        ? S_DONE : S_DIV_INIT;
                        OP_READ: n_st = S_READ;
                        OP_FOG:  n_st = S_FOG1;
                        default: n_st = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                w_mem_addr = r_pidx[AW-1:0];
                if ({1'b0, r_pidx} < 10'(r_cnt) && 32'(r_pidx) < MAX_PARTICLES) begin
                    n_ov = 1'b1;
                    n_st = S_CP_RD;
                    n_step = 6'd1;
                end else begin
                    n_st = S_DONE;
                end
            end
            S_FOG1: begin
                if (r_kind == KIND_FOG) begin
                    w_ma = {24'd0, r_pix};
                    w_mb = 32'(OneQ16 - r_str);
                    n_acc = w_prod;
                    n_st = S_FOG2;
                end else begin
                    n_opx = r_pix;
                    n_st = S_DONE;
                end
            end
            S_FOG2: begin
                w_ma = {15'd0, r_str} >> 9;
                w_mb = {15'd0, r_str};
                w_dsub = r_acc + w_prod;
                n_opx = w_dsub[23:16];
                n_st = S_DONE;
            end
            S_DIV_INIT: begin
                w_csum = {1'b0, r_clk} + 33'(r_dt);
                n_clk = w_csum[32] ? 32'hFFFFFFFF : w_csum[31:0];
                w_ma = 32'd200;
                w_mb = {15'd0, r_str};
                n_wd = w_prod[31:0];     // divisor held here
                n_acc = 64'd0;
                n_q = 33'd0;
                n_step = 6'd32;
                n_st = S_DIV;
            end
            S_DIV: begin
                // restoring divide of 2^32 by divisor, one bit a cycle
                w_dsub = {r_acc[62:0], (r_step == 6'd32)};
                if (w_dsub >= {32'd0, r_wd}) begin
                    n_acc = w_dsub - {32'd0, r_wd};
                    n_q = {r_q[31:0], 1'b1};
                end else begin
                    n_acc = w_dsub;
                    n_q = {r_q[31:0], 1'b0};
                end
                if (r_step == 6'd0) begin
                    if (n_q < 33'(MinInterval)) n_q = 33'(MinInterval);
                    n_st = S_SPAWN_CHK;
                end else begin
                    n_step = r_step - 6'd1;
                end
            end
            S_SPAWN_CHK: begin
                if (33'(r_clk) >= r_q && r_cnt < MaxCnt) begin
                    n_clk = r_clk - r_q[31:0];
                    n_dn = 2'd0;
                    n_st = S_DRAW;
                end else begin
                    n_st = S_WIND;
                end
            end
            S_DRAW: begin
                w_ma = r_rng;
                w_mb = LcgMul;
                n_rng = w_prod[31:0] + LcgAdd;
                n_st = S_SCALE;
            end
            S_SCALE: begin
                // value * 655.36 as value*16384/25, kept within 32 bits
                unique case (r_dn)
                    2'd0, 2'd1: n_acc = {32'd0, w_draw} << 14;
                    2'd2: n_acc = {32'd0, 32'd200 + (w_draw << 1)} << 14;
                    default: n_acc = {32'd0, 32'd2 + w_draw * 32'd3} << 14;
                endcase
                n_st = S_SCALE2;
            end
            S_SCALE2: begin
                // floor(v/25) = (v * 2748779070) >> 36 for v < 2^32
                w_ma = r_acc[31:0];
                w_mb = 32'd2748779070;
                w_dsub = w_prod >> 36;
                if ((w_dsub + 64'd1) * 64'd25 <= {32'd0, r_acc[31:0]}) begin
                    w_dsub = w_dsub + 64'd1;
                end
                unique case (r_dn)
                    2'd0: n_x = w_dsub[31:0];
                    2'd1: n_y = w_dsub[31:0];
                    2'd2: n_sp = w_dsub[25:0];
                    default: n_ln = w_dsub[25:0];
                endcase
                n_al = r_str;
                if (r_dn == 2'd3) begin
                    n_st = S_SPAWN_WR;
                end else begin
                    n_dn = r_dn + 2'd1;
                    n_st = S_DRAW;
                end
            end
            S_SPAWN_WR: begin
                w_mem_addr = r_cnt[AW-1:0];
                w_mem_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                n_st = S_SPAWN_CHK;
            end
            S_WIND: begin
                w_ma = r_wnd_mag;
                w_mb = {8'd0, r_dt};
                n_acc = w_prod >> 16;
                n_st = S_WIND2;
            end
            S_WIND2: begin
                n_wd = r_wind[23] ? -$signed(r_acc[31:0]) : $signed(r_acc[31:0]);
                n_idx = '0;
                n_st = S_MV_RD;
            end
            S_MV_RD: begin
                if (r_idx < r_cnt) n_st = S_MV_MUL;
                else n_st = S_DONE;
            end
            S_MV_MUL: begin
                {n_x, n_y, n_sp, n_ln, n_al} = r_rdata;
                n_st = S_MV_ADD;
            end
            S_MV_ADD: begin
                w_ma = {6'd0, r_sp};
                w_mb = {8'd0, r_dt};
                w_dsub = w_prod >> 16;
                w_ny = 36'($signed(r_y)) + $signed({2'b00, w_dsub[33:0]});
                w_nx = 36'($signed(r_x)) + 36'(r_wd);
                w_sy = sat32(w_ny);
                w_sx = sat32(w_nx);
                n_y = w_sy;
                n_x = w_sx;
                n_st = S_MV_CHK;
            end
            S_MV_CHK: begin
                if ($signed(r_y) > 32'sd65536 || $signed(r_x) < 0 ||
                    $signed(r_x) > 32'sd65536) begin
                    n_cnt = r_cnt - 1'b1;
                    w_mem_addr = n_cnt[AW-1:0];
                    n_step = 6'd0;
                    n_st = S_CP_RD;
                end else begin
                    w_mem_we = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_st = S_MV_RD;
                end
            end
            S_CP_RD: begin
                // hold the address so the read data survives into the next cycle
                w_mem_addr = (r_step == 6'd1) ? r_pidx[AW-1:0] : r_cnt[AW-1:0];
                n_st = S_CP_WR;
            end
            S_CP_WR: begin
                if (r_step == 6'd1) begin
                    {n_ox, n_oy, n_osp, n_oln, n_oal} = r_rdata;
                    n_st = S_DONE;
                end else begin
                    w_mem_we = 1'b1;
                    w_mem_wdata = r_rdata;
                    n_st = S_MV_RD;
                end
            end
            S_DONE: begin
                n_done = 1'b1;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
        if (r_st == S_MV_RD) w_mem_addr = r_idx[AW-1:0];
    end

endmodule

[hdl/pfu_checker.sv]
module pfu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [9:0] o_live_count,
    input logic       o_entry_valid,
    input logic [7:0] o_pixel_out
);
    import pfu_pkg::*;

    // accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("busy not raised");

    // done is a single pulse
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");

    // done only while busy is low
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");

    // live count bounded
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_live_count <= 10'd512) else $error("count overflow");

endmodule

bind particle_field_update_unit pfu_checker u_pfu_checker (.*);
